@@ src/hwpid_pkg.sv @@
// ----------------------------------------------------------------------------
// hwpid_pkg
// Shared constants, types and arithmetic helpers for the heater warm-up PID.
// ----------------------------------------------------------------------------
package hwpid_pkg;

   localparam int TEMP_FRAC_BITS = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_TEMP    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONFIRM_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WARMUP_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P         = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DRIVE      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_INTEGRAL   = 3'd7;

   localparam logic [14:0] RST_TARGET_TEMP    = 15'd10240;
   localparam logic [15:0] RST_CONFIRM_COUNT  = 16'd200;
   localparam logic [31:0] RST_WARMUP_TIMEOUT = 32'd20000;
   localparam logic [31:0] RST_GAIN_P         = 32'd104857600;
   localparam logic [31:0] RST_GAIN_I         = 32'd13107;
   localparam logic [31:0] RST_GAIN_D         = 32'd0;
   localparam logic [15:0] RST_MAX_DRIVE      = 16'd4500;
   localparam logic [15:0] RST_MAX_INTEGRAL   = 16'd4400;

   // accepted target window, 20 to 70 degrees
   localparam logic [31:0] TARGET_MIN = 32'(20 << TEMP_FRAC_BITS);
   localparam logic [31:0] TARGET_MAX = 32'(70 << TEMP_FRAC_BITS);

   localparam int Q24    = 24;
   localparam int ERR_W  = 17;
   localparam int PROD_W = 51;   // 33-bit gain times 18-bit difference
   localparam int TERM_W = 58;   // Q24 terms and their sums
   localparam int ACC_W  = 48;   // integral accumulator

   localparam int SHR = (TEMP_FRAC_BITS >= 8) ? TEMP_FRAC_BITS - 8 : 0;
   localparam int SHL = (TEMP_FRAC_BITS < 8) ? 8 - TEMP_FRAC_BITS : 0;

   // kind of request traveling down the pipe
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_WARM = 2'd1;
   localparam logic [1:0] KIND_PID  = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] temp;
   } s1_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic                      locked;
      logic                      lock_evt;
      logic signed [TERM_W-1:0]  p;
      logic signed [TERM_W-1:0]  i;
      logic signed [TERM_W-1:0]  d;
   } s2_type;

   typedef struct packed {
      logic [1:0]                kind;
      logic                      locked;
      logic signed [TERM_W-1:0]  pd;
      logic signed [ACC_W-1:0]   integ;
   } s3_type;

   // gain product to Q24 counts: floor shift right or exact scale left
   function automatic logic signed [TERM_W-1:0] scale_term(
      input logic signed [PROD_W-1:0] prod);
      logic signed [TERM_W-1:0] w;
      w = TERM_W'(prod);
      return (w >>> SHR) <<< SHL;
   endfunction

   // clamp to +-lim counts in Q24
   function automatic logic signed [TERM_W-1:0] clamp_sym(
      input logic signed [TERM_W-1:0] v,
      input logic [15:0]              lim);
      logic signed [TERM_W-1:0] m;
      m = $signed(TERM_W'({lim, 24'd0}));
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

endpackage

@@ src/hwpid_req_if.sv @@
// ----------------------------------------------------------------------------
// hwpid_req_if
// Request channel: millisecond tick or temperature sample.
// ----------------------------------------------------------------------------
interface hwpid_req_if;
   logic               valid;
   logic               ready;
   logic               cmd;
   logic signed [15:0] temp_sample;

   modport source (output valid, output cmd, output temp_sample, input ready);
   modport sink   (input valid, input cmd, input temp_sample, output ready);
endinterface

@@ src/hwpid_rsp_if.sv @@
// ----------------------------------------------------------------------------
// hwpid_rsp_if
// Result channel: heater PWM compare value and lock status.
// ----------------------------------------------------------------------------
interface hwpid_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] heater_pwm;
   logic        locked;

   modport source (output valid, output heater_pwm, output locked, input ready);
   modport sink   (input valid, input heater_pwm, input locked, output ready);
endinterface

@@ src/heater_warmup_pid_controller_unit.sv @@
// ----------------------------------------------------------------------------
// heater_warmup_pid_controller_unit
// Heater warm-up sequencer and positional PID with integral preset on lock.
// ----------------------------------------------------------------------------
// Path from request accept to result valid: input reg, product stage,
//   integral stage, output reg.
// Throughput: one request per cycle while the result channel is not stalled;
//   each stage holds its own state so the integral and previous-error loops close locally.
// Reset (synchronous): pipeline empty, controller unlocked, PWM zero,
//   configuration registers at their defaults.
module heater_warmup_pid_controller_unit
   import hwpid_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   hwpid_req_if.sink             req_if,
   hwpid_rsp_if.source           rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [14:0] target_temp_ff,    target_temp_in;
   logic [15:0] confirm_count_ff,  confirm_count_in;
   logic [31:0] warmup_timeout_ff, warmup_timeout_in;
   logic [31:0] gain_p_ff,         gain_p_in;
   logic [31:0] gain_i_ff,         gain_i_in;
   logic [31:0] gain_d_ff,         gain_d_in;
   logic [15:0] max_drive_ff,      max_drive_in;
   logic [15:0] max_integral_ff,   max_integral_in;

   // controller state
   logic                     lock_flag_ff,  lock_flag_in;
   logic [15:0]              above_run_ff,  above_run_in;
   logic                     started_ff,    started_in;
   logic [31:0]              elapsed_ff,    elapsed_in;
   logic signed [ACC_W-1:0]  integ_ff,      integ_in;
   logic signed [ERR_W-1:0]  prev_err_ff,   prev_err_in;
   logic [15:0]              pwm_ff,        pwm_in;
   logic                     locked_out_ff, locked_out_in;

   // pipeline
   logic   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   logic free1, free2, free3, free4;
   logic load2, load3, load4, accept;

   assign free4  = !v4_ff || rsp_if.ready;
   assign load4  = v3_ff && free4;
   assign free3  = !v3_ff || free4;
   assign load3  = v2_ff && free3;
   assign free2  = !v2_ff || free3;
   assign load2  = v1_ff && free2;
   assign free1  = !v1_ff || free2;
   assign accept = req_if.valid && free1;

   assign req_if.ready      = free1;
   assign rsp_if.valid      = v4_ff;
   assign rsp_if.heater_pwm = pwm_ff;
   assign rsp_if.locked     = locked_out_ff;

   // ---------------------------------------------------------------- config
   always_comb begin
      target_temp_in    = target_temp_ff;
      confirm_count_in  = confirm_count_ff;
      warmup_timeout_in = warmup_timeout_ff;
      gain_p_in         = gain_p_ff;
      gain_i_in         = gain_i_ff;
      gain_d_in         = gain_d_ff;
      max_drive_in      = max_drive_ff;
      max_integral_in   = max_integral_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_TEMP: begin
               // out-of-window targets are dropped
               if (32'(csr_wdata[14:0]) >= TARGET_MIN &&
                   32'(csr_wdata[14:0]) <= TARGET_MAX) begin
                  target_temp_in = csr_wdata[14:0];
               end
            end
            REG_CONFIRM_COUNT:  confirm_count_in  = csr_wdata[15:0];
            REG_WARMUP_TIMEOUT: warmup_timeout_in = csr_wdata;
            REG_GAIN_P:         gain_p_in         = csr_wdata;
            REG_GAIN_I:         gain_i_in         = csr_wdata;
            REG_GAIN_D:         gain_d_in         = csr_wdata;
            REG_MAX_DRIVE:      max_drive_in      = csr_wdata[15:0];
            REG_MAX_INTEGRAL:   max_integral_in   = csr_wdata[15:0];
         endcase
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in.cmd  = req_if.cmd;
         s1_in.temp = req_if.temp_sample;
      end
      v1_in = accept ? 1'b1 : (load2 ? 1'b0 : v1_ff);
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [17:0]       err_wide;
   logic signed [ERR_W-1:0]  err;
   logic signed [17:0]       diff;
   logic signed [PROD_W-1:0] prod_p, prod_i, prod_d;
   logic signed [16:0]       temp_ext, target_ext;
   logic                     above;
   logic [15:0]              run_inc;
   logic                     is_warm, is_pid, lock_evt;

   always_comb begin
      temp_ext   = 17'(s1_ff.temp);
      target_ext = $signed({2'b00, target_temp_ff});
      err_wide   = $signed({3'b000, target_temp_ff}) - 18'(s1_ff.temp);
      if (err_wide > 18'sd65535) begin
         err = 17'sd65535;
      end else if (err_wide < -18'sd65536) begin
         err = -17'sd65536;
      end else begin
         err = err_wide[ERR_W-1:0];
      end
      diff   = 18'(err) - 18'(prev_err_ff);
      prod_p = $signed({1'b0, gain_p_ff}) * err;
      prod_i = $signed({1'b0, gain_i_ff}) * err;
      prod_d = $signed({1'b0, gain_d_ff}) * diff;

      is_warm  = s1_ff.cmd && !lock_flag_ff;
      is_pid   = s1_ff.cmd && lock_flag_ff;
      above    = temp_ext > target_ext;
      run_inc  = (above_run_ff == 16'hFFFF) ? above_run_ff : above_run_ff + 16'd1;
      // timeout is checked only on samples at or below target
      lock_evt = is_warm && (above ? (run_inc > confirm_count_ff)
                                   : (elapsed_ff > warmup_timeout_ff));

      lock_flag_in = lock_flag_ff;
      above_run_in = above_run_ff;
      started_in   = started_ff;
      elapsed_in   = elapsed_ff;
      prev_err_in  = prev_err_ff;
      if (load2) begin
         if (!s1_ff.cmd) begin
            if (started_ff && elapsed_ff != 32'hFFFF_FFFF) begin
               elapsed_in = elapsed_ff + 32'd1;
            end
         end else if (is_warm) begin
            started_in   = 1'b1;
            above_run_in = above ? run_inc : 16'd0;
            lock_flag_in = lock_evt;
         end else begin
            prev_err_in = err;
         end
      end

      s2_in = s2_ff;
      if (load2) begin
         s2_in.kind     = !s1_ff.cmd ? KIND_TICK : (is_pid ? KIND_PID : KIND_WARM);
         s2_in.locked   = lock_flag_ff || lock_evt;
         s2_in.lock_evt = lock_evt;
         s2_in.p        = scale_term(prod_p);
         s2_in.i        = scale_term(prod_i);
         s2_in.d        = scale_term(prod_d);
      end
      v2_in = load2 ? 1'b1 : (load3 ? 1'b0 : v2_ff);
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [TERM_W-1:0] integ_sum;

   always_comb begin
      integ_sum = clamp_sym(TERM_W'(integ_ff) + s2_ff.i, max_integral_ff);
      integ_in  = integ_ff;
      if (load3) begin
         if (s2_ff.lock_evt) begin
            // preset to half of max drive
            integ_in = $signed(ACC_W'({max_drive_ff, 23'd0}));
         end else if (s2_ff.kind == KIND_PID) begin
            integ_in = integ_sum[ACC_W-1:0];
         end
      end
      s3_in = s3_ff;
      if (load3) begin
         s3_in.kind   = s2_ff.kind;
         s3_in.locked = s2_ff.locked;
         s3_in.pd     = s2_ff.p + s2_ff.d;
         s3_in.integ  = integ_in;
      end
      v3_in = load3 ? 1'b1 : (load4 ? 1'b0 : v3_ff);
   end

   // ---------------------------------------------------------------- stage 4
   logic signed [TERM_W-1:0] out_sum;
   logic [15:0]              pwm_pid, full_power;

   always_comb begin
      out_sum    = clamp_sym(s3_ff.pd + TERM_W'(s3_ff.integ), max_drive_ff);
      pwm_pid    = (out_sum < 0) ? 16'd0 : out_sum[Q24+15:Q24];
      full_power = (max_drive_ff == 16'd0) ? 16'd0 : max_drive_ff - 16'd1;
      pwm_in        = pwm_ff;
      locked_out_in = locked_out_ff;
      if (load4) begin
         unique case (s3_ff.kind)
            KIND_TICK: pwm_in = pwm_ff;
            KIND_WARM: pwm_in = full_power;
            KIND_PID:  pwm_in = pwm_pid;
            default:   pwm_in = pwm_ff;
         endcase
         locked_out_in = s3_ff.locked;
      end
      v4_in = load4 ? 1'b1 : (rsp_if.ready ? 1'b0 : v4_ff);
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_temp_ff    <= RST_TARGET_TEMP;
         confirm_count_ff  <= RST_CONFIRM_COUNT;
         warmup_timeout_ff <= RST_WARMUP_TIMEOUT;
         gain_p_ff         <= RST_GAIN_P;
         gain_i_ff         <= RST_GAIN_I;
         gain_d_ff         <= RST_GAIN_D;
         max_drive_ff      <= RST_MAX_DRIVE;
         max_integral_ff   <= RST_MAX_INTEGRAL;
         lock_flag_ff      <= 1'b0;
         above_run_ff      <= 16'd0;
         started_ff        <= 1'b0;
         elapsed_ff        <= 32'd0;
         integ_ff          <= '0;
         prev_err_ff       <= '0;
         pwm_ff            <= 16'd0;
         locked_out_ff     <= 1'b0;
         v1_ff             <= 1'b0;
         v2_ff             <= 1'b0;
         v3_ff             <= 1'b0;
         v4_ff             <= 1'b0;
      end else begin
         target_temp_ff    <= target_temp_in;
         confirm_count_ff  <= confirm_count_in;
         warmup_timeout_ff <= warmup_timeout_in;
         gain_p_ff         <= gain_p_in;
         gain_i_ff         <= gain_i_in;
         gain_d_ff         <= gain_d_in;
         max_drive_ff      <= max_drive_in;
         max_integral_ff   <= max_integral_in;
         lock_flag_ff      <= lock_flag_in;
         above_run_ff      <= above_run_in;
         started_ff        <= started_in;
         elapsed_ff        <= elapsed_in;
         integ_ff          <= integ_in;
         prev_err_ff       <= prev_err_in;
         pwm_ff            <= pwm_in;
         locked_out_ff     <= locked_out_in;
         v1_ff             <= v1_in;
         v2_ff             <= v2_in;
         v3_ff             <= v3_in;
         v4_ff             <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
   end

`ifndef ASSERT_OFF
   // lock is sticky until reset
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      lock_flag_ff |=> lock_flag_ff)
      else $error("lock flag dropped");

   // warm-up timer does not run before the first sample
   a_elapsed_idle: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> elapsed_ff == 32'd0)
      else $error("elapsed time counted before first sample");

   // an accepted request lands in the input register
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> v1_ff)
      else $error("accepted request lost");
`endif

endmodule

@@ sim/tb_heater_warmup_pid_controller_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heater_warmup_pid_controller_unit
// Checks the heater warm-up sequencer and PID against a cycle-free predictor.
// Requests are fed from a queue through a randomly idling driver. Results are
// taken by a randomly stalling monitor and compared in order with the
// predicted PWM and lock status. The run covers warm-up, a long above-target
// run, a single lock, and several PID settings.
// ----------------------------------------------------------------------------
module tb_heater_warmup_pid_controller_unit
   import hwpid_pkg::*;
;

   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [14:0] TARGET_LO = 15'(20 << TEMP_FRAC_BITS);
   localparam logic [14:0] TARGET_HI = 15'(70 << TEMP_FRAC_BITS);
   localparam int TEMP_MIN = -10240;
   localparam int TEMP_MAX = 32000;

   typedef struct packed {
      logic               cmd;
      logic signed [15:0] temp;
   } heater_req_type;

   typedef struct packed {
      logic [15:0] heater_pwm;
      logic        locked;
   } heater_status_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hwpid_req_if req_bus ();
   hwpid_rsp_if rsp_bus ();

   heater_warmup_pid_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // configuration shadow
   logic [14:0] cfg_target       = RST_TARGET_TEMP;
   logic [15:0] cfg_confirm      = RST_CONFIRM_COUNT;
   logic [31:0] cfg_timeout      = RST_WARMUP_TIMEOUT;
   logic [31:0] cfg_kp           = RST_GAIN_P;
   logic [31:0] cfg_ki           = RST_GAIN_I;
   logic [31:0] cfg_kd           = RST_GAIN_D;
   logic [15:0] cfg_max_drive    = RST_MAX_DRIVE;
   logic [15:0] cfg_max_integral = RST_MAX_INTEGRAL;

   // controller state as predicted
   bit          locked_st   = 1'b0;
   logic [15:0] above_cnt   = '0;
   bit          started_st  = 1'b0;
   logic [31:0] elapsed_st  = '0;
   longint      integ_st    = 0;
   int          prev_err_st = 0;
   logic [15:0] pwm_st      = '0;

   heater_req_type    heater_req_q[$];
   heater_status_type status_q[$];

   int  items_queued = 0;
   int  items_taken  = 0;
   int  mismatches   = 0;
   bit  req_accepted = 1'b0;
   int  req_gap      = 0;
   int  rsp_gap      = 0;
   int  idle_odds    = 8;
   bit  no_idle      = 1'b0;
   bit  long_stall_req  = 1'b0;
   bit  long_stall_done = 1'b0;
   int  long_stall_left = 0;

   // gain * error in Q16.16 x Q(frac) -> Q24 counts
   function automatic longint gain_term(input logic [31:0] gain, input int e);
      longint prod;
      prod = longint'(gain) * longint'(e);
      return (prod >>> SHR) <<< SHL;
   endfunction

   function automatic longint clamp_q24(input longint v, input logic [15:0] lim);
      longint m;
      m = longint'(lim) <<< 24;
      if (v > m) return m;
      if (v < -m) return -m;
      return v;
   endfunction

   function automatic heater_status_type advance_heater(input logic cmd,
                                                        input logic signed [15:0] t);
      heater_status_type r;
      int     e;
      longint p, d, sum;
      if (cmd == CMD_TICK) begin
         if (started_st && elapsed_st != 32'hFFFF_FFFF) elapsed_st++;
      end else if (locked_st) begin
         e = int'(cfg_target) - int'(t);
         if (e > 65535) e = 65535;
         if (e < -65536) e = -65536;
         p = gain_term(cfg_kp, e);
         integ_st = clamp_q24(integ_st + gain_term(cfg_ki, e), cfg_max_integral);
         d = gain_term(cfg_kd, e - prev_err_st);
         prev_err_st = e;
         sum = clamp_q24(p + integ_st + d, cfg_max_drive);
         if (sum < 0) sum = 0;
         pwm_st = 16'(sum >>> 24);
      end else begin
         started_st = 1'b1;
         if (int'(t) > int'(cfg_target)) begin
            if (above_cnt != 16'hFFFF) above_cnt++;
            if (above_cnt > cfg_confirm) begin
               locked_st = 1'b1;
               integ_st  = longint'(cfg_max_drive) <<< 23;
            end
         end else begin
            above_cnt = '0;
            // timeout is only looked at on samples not above target
            if (elapsed_st > cfg_timeout) begin
               locked_st = 1'b1;
               integ_st  = longint'(cfg_max_drive) <<< 23;
            end
         end
         pwm_st = (cfg_max_drive != 0) ? cfg_max_drive - 16'd1 : 16'd0;
      end
      r.heater_pwm = pwm_st;
      r.locked     = locked_st;
      return r;
   endfunction

   function automatic logic signed [15:0] temp_any();
      return 16'(int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
   endfunction

   function automatic logic signed [15:0] temp_near(input int center, input int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < TEMP_MIN) v = TEMP_MIN;
      if (v > TEMP_MAX) v = TEMP_MAX;
      return 16'(v);
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         3, 4, 5: return $urandom_range(0, 32'h0800_0000);
         default: return $urandom_range(0, 32'h0002_0000);
      endcase
   endfunction

   task automatic push_item(input logic cmd, input logic signed [15:0] t);
      heater_req_type it;
      it.cmd  = cmd;
      it.temp = t;
      heater_req_q.push_back(it);
      items_queued++;
   endtask

   // wait until every request has been answered, then let the pipe settle
   task automatic drain();
      while (items_taken != items_queued || status_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      logic [14:0] tv;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         REG_TARGET_TEMP: begin
            tv = data[14:0];
            if (tv >= TARGET_LO && tv <= TARGET_HI) cfg_target = tv;
         end
         REG_CONFIRM_COUNT:  cfg_confirm      = data[15:0];
         REG_WARMUP_TIMEOUT: cfg_timeout      = data;
         REG_GAIN_P:         cfg_kp           = data;
         REG_GAIN_I:         cfg_ki           = data;
         REG_GAIN_D:         cfg_kd           = data;
         REG_MAX_DRIVE:      cfg_max_drive    = data[15:0];
         REG_MAX_INTEGRAL:   cfg_max_integral = data[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin : req_driver
      heater_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_accepted) begin
         if (req_gap > 0) begin
            req_bus.valid <= 1'b0;
            req_gap--;
         end else if (!no_idle && $urandom_range(0, idle_odds) == 0) begin
            req_bus.valid <= 1'b0;
            req_gap = $urandom_range(0, 14);
         end else if (heater_req_q.size() != 0) begin
            nxt = heater_req_q.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.cmd         <= nxt.cmd;
            req_bus.temp_sample <= nxt.temp;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result ready, with random stalls and one long hold-off
   always @(negedge clock) begin : rsp_stall
      if (long_stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         long_stall_left--;
      end else if (long_stall_req && !long_stall_done) begin
         rsp_bus.ready <= 1'b0;
         long_stall_left = 299;
         long_stall_done = 1'b1;
      end else if (rsp_gap != 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap--;
      end else if (!no_idle && $urandom_range(0, idle_odds) == 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = $urandom_range(0, 14);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // accept side prediction and result checking
   always @(posedge clock) begin : monitor
      heater_status_type want;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         req_accepted = req_bus.valid && req_bus.ready;
         if (req_accepted) begin
            status_q.push_back(advance_heater(req_bus.cmd, req_bus.temp_sample));
            items_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (status_q.size() == 0) begin
               $error("unexpected result: heater_pwm %0d locked %0d",
                      rsp_bus.heater_pwm, rsp_bus.locked);
               mismatches++;
            end else begin
               want = status_q.pop_front();
               if (rsp_bus.heater_pwm !== want.heater_pwm) begin
                  $error("heater_pwm: expected %0d, actual %0d",
                         want.heater_pwm, rsp_bus.heater_pwm);
                  mismatches++;
               end
               if (rsp_bus.locked !== want.locked) begin
                  $error("locked: expected %0d, actual %0d", want.locked, rsp_bus.locked);
                  mismatches++;
               end
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int          ph, n, spread;
      int unsigned ov;
      logic [31:0] gp, gi, gd;
      logic [15:0] md, mi;
      logic [14:0] tgt;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.cmd         = CMD_TICK;
      req_bus.temp_sample = '0;
      rsp_bus.ready       = 1'b0;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_wdata           = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ticks before the first sample are not counted
      repeat (3) push_item(CMD_TICK, temp_any());
      push_item(CMD_SAMPLE, 16'(TEMP_MIN));
      push_item(CMD_SAMPLE, 16'(TEMP_MAX));
      push_item(CMD_SAMPLE, 16'(int'(cfg_target)));
      push_item(CMD_SAMPLE, 16'(int'(cfg_target) + 1));
      push_item(CMD_SAMPLE, 16'(int'(cfg_target) - 1));
      push_item(CMD_TICK, temp_any());
      drain();

      // out-of-window target writes are dropped, upper bits are masked
      write_reg(REG_TARGET_TEMP, 32'(TARGET_LO) - 1);
      write_reg(REG_TARGET_TEMP, 32'(TARGET_HI) + 1);
      write_reg(REG_TARGET_TEMP, 32'h8000 | 32'(TARGET_LO));
      push_item(CMD_SAMPLE, 16'(TARGET_LO));
      push_item(CMD_SAMPLE, 16'(TARGET_LO + 1));
      drain();
      write_reg(REG_TARGET_TEMP, 32'(TARGET_HI));
      push_item(CMD_SAMPLE, 16'(TARGET_HI));
      push_item(CMD_SAMPLE, 16'(TARGET_HI + 1));
      drain();

      // full power with zero, largest and smallest drive limit
      write_reg(REG_MAX_DRIVE, 32'hABCD_0000);
      push_item(CMD_SAMPLE, temp_any());
      drain();
      write_reg(REG_MAX_DRIVE, 32'h0000_FFFF);
      push_item(CMD_SAMPLE, temp_any());
      drain();
      write_reg(REG_MAX_DRIVE, 32'h5A5A_0001);
      push_item(CMD_SAMPLE, temp_any());
      drain();

      // elapsed equal to the timeout does not lock yet
      write_reg(REG_CONFIRM_COUNT, 32'hFFFF_FFFF);
      push_item(CMD_TICK, temp_any());
      push_item(CMD_TICK, temp_any());
      drain();
      write_reg(REG_WARMUP_TIMEOUT, elapsed_st);
      push_item(CMD_SAMPLE, 16'(int'(cfg_target) - 5));
      drain();
      write_reg(REG_WARMUP_TIMEOUT, 32'hFFFF_FFFF);

      // warm-up noise around the target; no lock possible with these limits
      write_reg(REG_MAX_DRIVE, $urandom());
      for (n = 0; n < 150; n++) begin
         if ($urandom_range(0, 1) == 0) push_item(CMD_TICK, temp_any());
         else if ($urandom_range(0, 3) == 0) push_item(CMD_SAMPLE, temp_any());
         else push_item(CMD_SAMPLE, temp_near(int'(cfg_target), 300));
      end
      drain();

      // run above target with a lapsed timeout: above-target samples never
      // trigger the timeout
      write_reg(REG_WARMUP_TIMEOUT, 32'd0);
      idle_odds = 20;
      push_item(CMD_TICK, temp_any());
      for (n = 0; n < 40; n++) begin
         if ($urandom_range(0, 15) == 0) push_item(CMD_TICK, temp_any());
         push_item(CMD_SAMPLE, 16'($urandom_range(int'(cfg_target) + 1, TEMP_MAX)));
      end
      drain();

      // lock, either by count or by timeout
      write_reg(REG_MAX_DRIVE, {16'($urandom()), 16'($urandom_range(1, 65535))});
      write_reg(REG_MAX_INTEGRAL, $urandom());
      if ($urandom_range(0, 1) == 0) begin
         write_reg(REG_CONFIRM_COUNT, $urandom_range(0, int'(above_cnt)));
         push_item(CMD_SAMPLE, 16'($urandom_range(int'(cfg_target) + 1, TEMP_MAX)));
      end else begin
         write_reg(REG_WARMUP_TIMEOUT, $urandom_range(0, elapsed_st - 1));
         push_item(CMD_SAMPLE, temp_near(int'(cfg_target) - 2000, 2000));
      end
      push_item(CMD_SAMPLE, 16'(int'(cfg_target)));
      push_item(CMD_SAMPLE, 16'(TEMP_MIN));
      push_item(CMD_SAMPLE, 16'(TEMP_MAX));
      push_item(CMD_TICK, temp_any());
      drain();

      for (ph = 0; ph < 6; ph++) begin
         gp = pick_gain();
         gi = pick_gain();
         gd = pick_gain();
         md = 16'($urandom_range(1, 65535));
         mi = 16'($urandom());
         case ($urandom_range(0, 3))
            0:       tgt = TARGET_LO;
            1:       tgt = TARGET_HI;
            default: tgt = 15'($urandom_range(TARGET_LO, TARGET_HI));
         endcase
         if (ph == 0) begin
            gp = '0;
            gi = '0;
            gd = '0;
            mi = '0;
         end else if (ph == 1) begin
            gp = 32'hFFFF_FFFF;
            gi = 32'hFFFF_FFFF;
            gd = 32'hFFFF_FFFF;
            md = 16'hFFFF;
            mi = 16'hFFFF;
         end else if (ph == 3) begin
            md = 16'd1;
         end
         if ($urandom_range(0, 1) == 0) begin
            ov = ($urandom_range(0, 1) == 0) ? $urandom_range(0, TARGET_LO - 1)
                                             : $urandom_range(TARGET_HI + 1, 32767);
            write_reg(REG_TARGET_TEMP, {17'($urandom()), 15'(ov)});
         end
         write_reg(REG_TARGET_TEMP, {17'($urandom()), tgt});
         write_reg(REG_CONFIRM_COUNT, $urandom());
         write_reg(REG_WARMUP_TIMEOUT, $urandom());
         write_reg(REG_GAIN_P, gp);
         write_reg(REG_GAIN_I, gi);
         write_reg(REG_GAIN_D, gd);
         write_reg(REG_MAX_DRIVE, {16'($urandom()), md});
         write_reg(REG_MAX_INTEGRAL, {16'($urandom()), mi});

         idle_odds = $urandom_range(3, 40);
         if (ph == 2) long_stall_req = 1'b1;
         if (ph == 5) no_idle = 1'b1;
         for (n = 0; n < 80; n++) begin
            case ($urandom_range(0, 2))
               0:       spread = 8;
               1:       spread = 128;
               default: spread = 1024;
            endcase
            if ($urandom_range(0, 4) == 0) push_item(CMD_TICK, temp_any());
            else if ($urandom_range(0, 7) == 0) push_item(CMD_SAMPLE, temp_any());
            else push_item(CMD_SAMPLE, temp_near(int'(cfg_target), spread));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/hwpid_pkg.sv
src/hwpid_req_if.sv
src/hwpid_rsp_if.sv
src/heater_warmup_pid_controller_unit.sv
sim/tb_heater_warmup_pid_controller_unit.sv
